// File: rtl/core/absl_pkg.sv
package absl_pkg;

  // number of slots in the set
  localparam int unsigned SLOTS = 5;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  localparam int unsigned KEY_W   = 56;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 3;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request key, restart scan
    logic scan;    // examine the slot under the scan index
    logic commit;  // stamp target, rekey on miss, load result
  } absl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;   // slot under the scan index holds the key
    logic last;    // scan index at the final slot
  } absl_sts_t;

endpackage

// File: rtl/core/assoc_batch_slot_lru_core.sv
// channel  | dir | tdata (low bit up)                          | tuser
// ---------+-----+---------------------------------------------+---------
// s_axis   | in  | stage_key, bitmap_group_key, sequence_key,  | -
//          |     | stencil_key (56 bits)                       |
// m_axis   | out | slot, zero fill (8 bits)                    | was_miss
//
// one request at a time: the transfer, a scan of one slot per cycle up to the
// first match or the last slot, then the update that stamps the slot and
// registers the result
// reset clears all slot keys, stamps and the use counter at once
// the update waits while an earlier result is still held on m_axis, and the
// next request is taken the cycle after the update
module assoc_batch_slot_lru_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // stage_key[15:0], bitmap_group_key[31:16],
                                        // sequence_key[47:32], stencil_key[55:48]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // slot[2:0], zero[7:3]
  output logic        m_axis_tuser_o    // was_miss[0]
);

  absl_pkg::absl_cmd_t cmd;
  absl_pkg::absl_sts_t sts;
  logic [absl_pkg::SLOT_W-1:0] slot;

  // sequencing: accept, scan, update, result hand-off
  absl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot keys, stamps, use counter, compare and minimum tracking
  absl_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (s_axis_tdata_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .slot_o (slot),
    .miss_o (m_axis_tuser_o)
  );

  // slot index padded to a whole byte
  assign m_axis_tdata_o = {{(8 - absl_pkg::SLOT_W){1'b0}}, slot};

endmodule

// File: rtl/core/absl_ctrl.sv
module absl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  absl_pkg::absl_sts_t sts_i,
  output absl_pkg::absl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load   = in_valid_i && (state_q == ST_IDLE);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_UPDATE) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.match || sts_i.last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/absl_dp.sv
module absl_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  absl_pkg::key_t                       key_i,
  input  absl_pkg::absl_cmd_t                  cmd_i,
  output absl_pkg::absl_sts_t                  sts_o,
  output logic [absl_pkg::SLOT_W-1:0]          slot_o,
  output logic                                 miss_o
);

  absl_pkg::key_t   keys_q   [absl_pkg::SLOTS];
  absl_pkg::stamp_t stamps_q [absl_pkg::SLOTS];
  absl_pkg::stamp_t counter_q;
  absl_pkg::stamp_t next_stamp;
  absl_pkg::stamp_t low_q;
  absl_pkg::key_t   key_q;
  absl_pkg::idx_t   idx_q;
  absl_pkg::idx_t   target_q;
  logic             hit_q;
  logic [absl_pkg::SLOT_W-1:0] slot_q;
  logic             miss_q;

  absl_pkg::key_t   cur_key;
  absl_pkg::stamp_t cur_stamp;
  logic             take_min;

  assign cur_key    = keys_q[idx_q];
  assign cur_stamp  = stamps_q[idx_q];
  assign next_stamp = counter_q + absl_pkg::stamp_t'(1);

  // first slot seeds the minimum, later ones replace it only when strictly lower
  assign take_min = (idx_q == '0) || (cur_stamp < low_q);

  assign sts_o.match = (cur_key == key_q);
  assign sts_o.last  = (idx_q == absl_pkg::idx_t'(absl_pkg::SLOTS - 1));

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      hit_q    <= 1'b0;
      target_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + absl_pkg::idx_t'(1);
      if (sts_o.match) begin
        hit_q    <= 1'b1;
        target_q <= idx_q;
      end else if (take_min) begin
        target_q <= idx_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
    end
    if (cmd_i.scan && !sts_o.match && take_min) begin
      low_q <= cur_stamp;
    end
    if (cmd_i.commit) begin
      slot_q <= absl_pkg::SLOT_W'(target_q);
      miss_q <= !hit_q;
    end
  end

  // slot state and use counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      for (int i = 0; i < absl_pkg::SLOTS; i++) begin
        keys_q[i]   <= '0;
        stamps_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      counter_q          <= next_stamp;
      stamps_q[target_q] <= next_stamp;
      if (!hit_q) begin
        keys_q[target_q] <= key_q;
      end
    end
  end

  assign slot_o = slot_q;
  assign miss_o = miss_q;

endmodule

// File: rtl/core/absl_checker.sv
module absl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_i,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tuser_i
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_i;

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result changed while stalled");

  // busy after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_i)
    else $error("request taken while previous one in progress");

  // a result needs at least the scan and update cycles
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !$rose(m_axis_tvalid_i) ##1 !$rose(m_axis_tvalid_i))
    else $error("result appeared too early");

  // slot index in range, fill bits zero
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      (m_axis_tdata_i[7:3] == 5'd0) &&
      ((absl_pkg::SLOTS > 8) || (32'(m_axis_tdata_i[2:0]) < absl_pkg::SLOTS)))
    else $error("slot index out of range");

endmodule

bind assoc_batch_slot_lru_core absl_checker u_absl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// File: tb/assoc_batch_slot_lru_core_tb.sv
`timescale 1ns / 1ps

module assoc_batch_slot_lru_core_tb;

  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned PHASES          = 4;
  localparam int unsigned POOL_SIZE       = 8;
  localparam int unsigned LONG_HOLD       = 200;   // cycles the output side holds off
  localparam int unsigned WATCHDOG_LIMIT  = 2000;  // idle cycles before the run is abandoned
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned SETTLE_CYCLES   = 2 * absl_pkg::SLOTS + 4;

  // request fields packed as on s_axis tdata: stage_key in the low bits
  typedef struct packed {
    logic [7:0]  stencil_key;
    logic [15:0] sequence_key;
    logic [15:0] bitmap_group_key;
    logic [15:0] stage_key;
  } slot_req_t;

  typedef struct packed {
    logic [absl_pkg::SLOT_W-1:0] slot;
    logic                        was_miss;
  } slot_res_t;

  // one row of the directed table; typed_ok marks a result written in by hand
  typedef struct {
    slot_req_t req;
    bit        typed_ok;
    slot_res_t typed;
  } dir_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i  = '0;  // stage_key, bitmap_group_key, sequence_key, stencil_key
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // slot, zero fill
  logic        m_axis_tuser_o;        // was_miss

  // predictor state: the keys and use stamps of the slot set
  slot_req_t        cached_key   [absl_pkg::SLOTS];
  absl_pkg::stamp_t cached_stamp [absl_pkg::SLOTS];
  absl_pkg::stamp_t use_count;

  slot_res_t   slot_expect_q [$];
  dir_row_t    dir_rows [$];
  slot_req_t   key_pool [POOL_SIZE];
  slot_res_t   seen_res;

  bit          quiet             = 1'b0;  // no idling on either side
  bit          long_hold_pending = 1'b0;
  int unsigned fails        = 0;
  int unsigned sent         = 0;
  int unsigned hits         = 0;
  int unsigned misses       = 0;
  int unsigned long_holds   = 0;
  int unsigned idle_cycles  = 0;

  assoc_batch_slot_lru_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // lookup with lru replacement: first matching slot hits, else the slot with
  // the lowest stamp (lowest index on a tie) takes the key
  function automatic slot_res_t lru_lookup(slot_req_t req);
    slot_res_t        res;
    int unsigned      victim;
    absl_pkg::stamp_t low_stamp;
    victim    = 0;
    low_stamp = cached_stamp[0];
    for (int i = 0; i < absl_pkg::SLOTS; i++) begin
      if (cached_key[i] == req) begin
        use_count       = use_count + 1'b1;
        cached_stamp[i] = use_count;
        res.slot        = absl_pkg::SLOT_W'(i);
        res.was_miss    = 1'b0;
        return res;
      end
      if (cached_stamp[i] < low_stamp) begin
        low_stamp = cached_stamp[i];
        victim    = i;
      end
    end
    cached_key[victim]   = req;
    use_count            = use_count + 1'b1;
    cached_stamp[victim] = use_count;
    res.slot             = absl_pkg::SLOT_W'(victim);
    res.was_miss         = 1'b1;
    return res;
  endfunction

  function automatic slot_req_t mk_req(logic [15:0] stage, logic [15:0] group,
                                       logic [15:0] seq, logic [7:0] stencil);
    slot_req_t req;
    req.stage_key        = stage;
    req.bitmap_group_key = group;
    req.sequence_key     = seq;
    req.stencil_key      = stencil;
    return req;
  endfunction

  function automatic slot_req_t rand_req();
    logic [63:0] rnd;
    slot_req_t   req;
    rnd = {$urandom(), $urandom()};
    req = rnd[55:0];
    return req;
  endfunction

  task automatic add_row(logic [15:0] stage, logic [15:0] group, logic [15:0] seq,
                         logic [7:0] stencil, bit typed_ok, int unsigned slot, bit miss);
    dir_row_t row;
    row.req            = mk_req(stage, group, seq, stencil);
    row.typed_ok       = typed_ok;
    row.typed.slot     = absl_pkg::SLOT_W'(slot);
    row.typed.was_miss = miss;
    dir_rows.push_back(row);
  endtask

  // offer one request after a random gap; the predictor runs on the transfer
  task automatic send_req(slot_req_t req, bit typed_ok, slot_res_t typed);
    int unsigned gap;
    slot_res_t   res;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= req;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    res = lru_lookup(req);
    slot_expect_q.push_back(typed_ok ? typed : res);
    sent++;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (slot_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // stimulus: directed table, then random phases with a small working set
  initial begin : stim
    slot_req_t   req;
    slot_res_t   no_typed;
    int unsigned pick;
    int unsigned ws_size [PHASES];
    ws_size  = '{3, 5, 6, 8};
    no_typed = '0;
    for (int i = 0; i < absl_pkg::SLOTS; i++) begin
      cached_key[i]   = '0;
      cached_stamp[i] = '0;
    end
    use_count = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_req();

    // zero key after reset hits slot 0 although every slot holds key zero
    add_row(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 0, 1'b0);
    // all ones misses; slots 1 to 4 tie at stamp zero, lowest index wins
    add_row(16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1, 1, 1'b1);
    add_row(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 0, 1'b0);
    add_row(16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1, 1, 1'b0);
    // one key part at its maximum, the rest zero, then the zero key again
    add_row(16'hffff, 16'h0000, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
    add_row(16'h0000, 16'hffff, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'hffff, 8'h00, 1'b0, 0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 8'hff, 1'b0, 0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
    // keys a single bit apart, repeats of earlier keys, and one with a single bit set in each part
    add_row(16'h0001, 16'h0000, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
    add_row(16'h0000, 16'h0000, 16'h0000, 8'h80, 1'b0, 0, 1'b0);
    add_row(16'h8000, 16'h0001, 16'h8000, 8'h01, 1'b0, 0, 1'b0);
    add_row(16'hffff, 16'h0000, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
    add_row(16'h0001, 16'h0000, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
    add_row(16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b0, 0, 1'b0);
    add_row(16'hffff, 16'hffff, 16'hffff, 8'hfe, 1'b0, 0, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) send_req(dir_rows[r].req, dir_rows[r].typed_ok, dir_rows[r].typed);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // the third phase runs flat out while the output side holds off
      quiet = (p == 2);
      if (p == 2) long_hold_pending = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p != 2 && n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 4) key_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_req();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          req = key_pool[$urandom_range(0, ws_size[p] - 1)];
        end else if (pick < 82) begin
          // near miss: a working-set key with one bit flipped
          req = key_pool[$urandom_range(0, ws_size[p] - 1)];
          req = req ^ (56'd1 << $urandom_range(0, 55));
        end else if (pick < 94) begin
          req = rand_req();
        end else if (pick < 97) begin
          req = '0;
        end else begin
          req = '1;
        end
        send_req(req, 1'b0, no_typed);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (slot_expect_q.size() != 0) begin
      $display("%0d expected results never arrived", slot_expect_q.size());
      fails++;
    end
    $display("covered %0d requests (%0d directed): %0d hits, %0d misses",
             sent, dir_rows.size(), hits, misses);
    $display("working sets of 3 to 8 keys, %0d long output hold-offs, %0d failures",
             long_holds, fails);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // output side: random stall before each result, one long hold-off on request
  initial begin : sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_pending) begin
        stall             = LONG_HOLD;
        long_hold_pending = 1'b0;
        long_holds++;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 9);
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (slot_expect_q.size() == 0) begin
        if (fails < MAX_REPORTS)
          $display("unexpected result: slot %0d was_miss %0b",
                   m_axis_tdata_o, m_axis_tuser_o);
        fails++;
      end else begin
        seen_res = slot_expect_q.pop_front();
        if (m_axis_tdata_o !== {{(8 - absl_pkg::SLOT_W){1'b0}}, seen_res.slot} ||
            m_axis_tuser_o !== seen_res.was_miss) begin
          if (fails < MAX_REPORTS)
            $display("mismatch: expected tdata %02h was_miss %0b, got tdata %02h was_miss %0b",
                     {{(8 - absl_pkg::SLOT_W){1'b0}}, seen_res.slot}, seen_res.was_miss,
                     m_axis_tdata_o, m_axis_tuser_o);
          fails++;
        end
        if (m_axis_tuser_o) misses++;
        else hits++;
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, slot_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
